>>> src/scc_pkg.sv
// shared constants, types and helpers for the sector cache controller
`default_nettype none

package scc_pkg;

  // cache geometry
  localparam int SLOTS    = 64;
  localparam int LANES    = (SLOTS >= 8) ? 8 : SLOTS;
  localparam int ROWS     = SLOTS / LANES;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;

  // sector numbers on the ports and as stored tags
  localparam int SECTOR_W    = 32;
  localparam int SECTOR_BITS = 32;
  localparam int TAG_W       = SECTOR_BITS;

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  typedef enum logic [1:0] {
    RD_LOOKUP,
    RD_HAND,
    RD_SCAN
  } rd_sel_e;

  typedef enum logic [1:0] {
    EMIT_HIT,
    EMIT_MISS,
    EMIT_FLUSH,
    EMIT_EMPTY
  } emit_kind_e;

  typedef struct packed {
    logic       lk_start;
    logic       lk_step;
    logic       sw_step;
    rd_sel_e    rd_sel;
    logic       emit;
    emit_kind_e emit_kind;
    logic       fl_start;
    logic       fl_next;
  } scc_cmd_t;

  typedef struct packed {
    logic out_free;
    logic hit;
    logic lk_miss;
    logic victim_found;
    logic any_dirty;
    logic scan_dirty;
    logic scan_row_end;
    logic scan_last;
  } scc_status_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [ROW_W-1:0] row,
                                                 input logic [LANE_W-1:0] lane);
    slot_of = SLOT_W'(SLOT_W'(row) * SLOT_W'(LANES)) + SLOT_W'(lane);
  endfunction

endpackage

`default_nettype wire

>>> src/scc_ram.sv
// generic single write port ram with registered read
`default_nettype none

module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/scc_dp.sv
// datapath: tag rams, slot state bits, clock hand, scan counters, result register
`default_nettype none

module scc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [1:0]                    command_i,
  input  wire logic [scc_pkg::SECTOR_W-1:0]  sector_i,
  input  wire scc_pkg::scc_cmd_t             cmd_i,
  output scc_pkg::scc_status_t               status_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic      [scc_pkg::SLOT_W-1:0]    slot_o,
  output logic                               hit_o,
  output logic                               writeback_o,
  output logic      [scc_pkg::SECTOR_W-1:0]  writeback_sector_o,
  output logic                               fill_o,
  output logic                               last_o
);

  import scc_pkg::*;

  // per-slot state, arranged as rows of lanes
  logic [ROWS-1:0][LANES-1:0] valid_q, valid_d;
  logic [ROWS-1:0][LANES-1:0] dirty_q, dirty_d;
  logic [ROWS-1:0][LANES-1:0] ref_q, ref_d;
  logic [ROWS-1:0][LANES-1:0] dv;
  logic [ROWS-1:0][LANES-1:0] scan_oh;

  logic [ROW_W-1:0]  hrow_q, hrow_d, nrow;
  logic [LANE_W-1:0] hlane_q, hlane_d, nlane;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_W-1:0]  cmp_row_q;
  logic              cmp_valid_q;
  logic [LANES-1:0]  match;
  logic [LANE_W-1:0] match_lane;
  logic [SLOT_W-1:0] hit_slot_q;

  logic [ROW_W-1:0]  srow_q, srow_d;
  logic [LANE_W-1:0] slane_q, slane_d;

  logic [TAG_W-1:0]  tag_q;
  logic              wr_q;

  logic [ROW_W-1:0]  raddr;
  logic [TAG_W-1:0]  rd_data [LANES];

  logic              out_valid_q;
  logic [SLOT_W-1:0] slot_q;
  logic              hit_q, wb_q, fill_q, last_q;
  logic [SECTOR_W-1:0] wbs_q;

  // ram read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_LOOKUP: raddr = row_q;
      RD_SCAN:   raddr = srow_q;
      default:   raddr = hrow_q;
    endcase
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    scc_ram #(
      .WIDTH (TAG_W),
      .DEPTH (ROWS)
    ) u_tag_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.emit && cmd_i.emit_kind == EMIT_MISS && hlane_q == LANE_W'(l)),
      .waddr_i (hrow_q),
      .wdata_i (tag_q),
      .raddr_i (raddr),
      .rdata_o (rd_data[l])
    );
  end

  // tag compare on the row read last cycle
  always_comb begin
    match_lane = '0;
    for (int l = 0; l < LANES; l++) begin
      match[l] = valid_q[cmp_row_q][l] && (rd_data[l] == tag_q);
    end
    for (int l = LANES - 1; l >= 0; l--) begin
      if (match[l]) begin
        match_lane = LANE_W'(l);
      end
    end
  end

  // next hand position
  always_comb begin
    if (hlane_q == LANE_W'(LANES - 1)) begin
      nlane = '0;
      nrow  = (hrow_q == ROW_W'(ROWS - 1)) ? '0 : hrow_q + 1'b1;
    end else begin
      nlane = hlane_q + 1'b1;
      nrow  = hrow_q;
    end
  end

  always_comb begin
    dv = valid_q & dirty_q;
    for (int r = 0; r < ROWS; r++) begin
      for (int l = 0; l < LANES; l++) begin
        scan_oh[r][l] = (srow_q == ROW_W'(r)) && (slane_q == LANE_W'(l));
      end
    end
  end

  assign status_o.out_free     = !out_valid_q || out_ready_i;
  assign status_o.hit          = cmp_valid_q && (|match);
  assign status_o.lk_miss      = cmp_valid_q && !(|match) && (cmp_row_q == ROW_W'(ROWS - 1));
  assign status_o.victim_found = !valid_q[nrow][nlane] || !ref_q[nrow][nlane];
  assign status_o.any_dirty    = |dv;
  assign status_o.scan_dirty   = dv[srow_q][slane_q];
  assign status_o.scan_row_end = (slane_q == LANE_W'(LANES - 1));
  // lower slots were already cleared in this flush
  assign status_o.scan_last    = ((dv & ~scan_oh) == '0);

  // state bit and counter updates
  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    ref_d   = ref_q;
    hrow_d  = hrow_q;
    hlane_d = hlane_q;
    row_d   = row_q;
    srow_d  = srow_q;
    slane_d = slane_q;

    if (cmd_i.lk_start) begin
      row_d = '0;
    end else if (cmd_i.lk_step && row_q != ROW_W'(ROWS - 1)) begin
      row_d = row_q + 1'b1;
    end

    if (cmd_i.sw_step) begin
      hrow_d  = nrow;
      hlane_d = nlane;
      if (!status_o.victim_found) begin
        ref_d[nrow][nlane] = 1'b0;
      end
    end

    if (cmd_i.fl_start) begin
      srow_d  = '0;
      slane_d = '0;
    end else if (cmd_i.fl_next) begin
      if (slane_q == LANE_W'(LANES - 1)) begin
        slane_d = '0;
        srow_d  = srow_q + 1'b1;
      end else begin
        slane_d = slane_q + 1'b1;
      end
    end

    if (cmd_i.emit) begin
      case (cmd_i.emit_kind)
        EMIT_HIT: begin
          ref_d[hit_slot_q[SLOT_W-1:LANE_W]][hit_slot_q[LANE_W-1:0]] = 1'b1;
          if (wr_q) begin
            dirty_d[hit_slot_q[SLOT_W-1:LANE_W]][hit_slot_q[LANE_W-1:0]] = 1'b1;
          end
        end
        EMIT_MISS: begin
          valid_d[hrow_q][hlane_q] = 1'b1;
          dirty_d[hrow_q][hlane_q] = wr_q;
          ref_d[hrow_q][hlane_q]   = 1'b1;
        end
        EMIT_FLUSH: begin
          dirty_d[srow_q][slane_q] = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      dirty_q     <= '0;
      ref_q       <= '0;
      hrow_q      <= '0;
      hlane_q     <= '0;
      row_q       <= '0;
      srow_q      <= '0;
      slane_q     <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      ref_q       <= ref_d;
      hrow_q      <= hrow_d;
      hlane_q     <= hlane_d;
      row_q       <= row_d;
      srow_q      <= srow_d;
      slane_q     <= slane_d;
      cmp_valid_q <= cmd_i.lk_step && !cmd_i.lk_start;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lk_start) begin
      tag_q <= TAG_W'(sector_i);
      wr_q  <= (command_i == CMD_WRITE);
    end
    if (cmd_i.lk_step) begin
      cmp_row_q <= row_q;
    end
    if (status_o.hit) begin
      hit_slot_q <= slot_of(cmp_row_q, match_lane);
    end
    if (cmd_i.emit) begin
      case (cmd_i.emit_kind)
        EMIT_HIT: begin
          slot_q <= hit_slot_q;
          hit_q  <= 1'b1;
          wb_q   <= 1'b0;
          wbs_q  <= '0;
          fill_q <= 1'b0;
          last_q <= 1'b1;
        end
        EMIT_MISS: begin
          slot_q <= slot_of(hrow_q, hlane_q);
          hit_q  <= 1'b0;
          wb_q   <= dv[hrow_q][hlane_q];
          wbs_q  <= dv[hrow_q][hlane_q] ? SECTOR_W'(rd_data[hlane_q]) : '0;
          fill_q <= 1'b1;
          last_q <= 1'b1;
        end
        EMIT_FLUSH: begin
          slot_q <= slot_of(srow_q, slane_q);
          hit_q  <= 1'b0;
          wb_q   <= 1'b1;
          wbs_q  <= SECTOR_W'(rd_data[slane_q]);
          fill_q <= 1'b0;
          last_q <= status_o.scan_last;
        end
        default: begin
          slot_q <= '0;
          hit_q  <= 1'b0;
          wb_q   <= 1'b0;
          wbs_q  <= '0;
          fill_q <= 1'b0;
          last_q <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign slot_o             = slot_q;
  assign hit_o              = hit_q;
  assign writeback_o        = wb_q;
  assign writeback_sector_o = wbs_q;
  assign fill_o             = fill_q;
  assign last_o             = last_q;

`ifndef NO_ASSERTIONS
  // valid slots never share a tag
  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_valid_q |-> $onehot0(match))
    else $error("more than one valid slot matches the tag");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted word not held in the result register");
`endif

endmodule

`default_nettype wire

>>> src/scc_ctrl.sv
// controller state machine for lookup, clock sweep and flush sequencing
`default_nettype none

module scc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           command_i,
  input  wire scc_pkg::scc_status_t status_i,
  output scc_pkg::scc_cmd_t         cmd_o
);

  import scc_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOOKUP   = 4'd1;
  localparam logic [3:0] S_HIT      = 4'd2;
  localparam logic [3:0] S_SWEEP    = 4'd3;
  localparam logic [3:0] S_VREAD    = 4'd4;
  localparam logic [3:0] S_VEMIT    = 4'd5;
  localparam logic [3:0] S_FL_ROW   = 4'd6;
  localparam logic [3:0] S_FL_SCAN  = 4'd7;
  localparam logic [3:0] S_FL_EMPTY = 4'd8;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.rd_sel    = RD_HAND;
    cmd_o.emit_kind = EMIT_HIT;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == CMD_READ || command_i == CMD_WRITE) begin
            cmd_o.lk_start = 1'b1;
            state_d        = S_LOOKUP;
          end else if (command_i == CMD_FLUSH) begin
            cmd_o.fl_start = 1'b1;
            state_d        = status_i.any_dirty ? S_FL_ROW : S_FL_EMPTY;
          end
        end
      end
      S_LOOKUP: begin
        cmd_o.lk_step = 1'b1;
        cmd_o.rd_sel  = RD_LOOKUP;
        if (status_i.hit) begin
          state_d = S_HIT;
        end else if (status_i.lk_miss) begin
          state_d = S_SWEEP;
        end
      end
      S_HIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EMIT_HIT;
          state_d         = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd_o.sw_step = 1'b1;
        if (status_i.victim_found) begin
          state_d = S_VREAD;
        end
      end
      S_VREAD: begin
        state_d = S_VEMIT;
      end
      S_VEMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EMIT_MISS;
          state_d         = S_IDLE;
        end
      end
      S_FL_ROW: begin
        cmd_o.rd_sel = RD_SCAN;
        state_d      = S_FL_SCAN;
      end
      S_FL_SCAN: begin
        cmd_o.rd_sel = RD_SCAN;
        if (status_i.scan_dirty) begin
          if (status_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = EMIT_FLUSH;
            if (status_i.scan_last) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.fl_next = 1'b1;
              state_d       = status_i.scan_row_end ? S_FL_ROW : S_FL_SCAN;
            end
          end
        end else begin
          cmd_o.fl_next = 1'b1;
          state_d       = status_i.scan_row_end ? S_FL_ROW : S_FL_SCAN;
        end
      end
      S_FL_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EMIT_EMPTY;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("word emitted while the result register is occupied");
`endif

endmodule

`default_nettype wire

>>> src/sector_cache_clock_replacement.sv
// top level of the sector cache tag and clock replacement controller
//
//   channel | handshake                 | word
//   in      | in_valid_i / in_ready_o   | command_i, sector_i
//   out     | out_valid_o / out_ready_i | slot_o, hit_o, writeback_o,
//           |                           | writeback_sector_o, fill_o, last_o
//
// one item at a time: a lookup reads a row of eight tags per cycle; a hit loads its word
// once its row has been compared; a miss scans every row, then steps the clock hand to
// a victim and reads its row, loading a writeback of the victim's tag if it was dirty.
// a flush loads a word per dirty slot up to the last; an empty flush loads one word.
// reset clears valid, dirty and reference bits and the hand at once; tags need no clearing.
// a full result register stalls each word's load until taken; intake waits for idle.
`default_nettype none

module sector_cache_clock_replacement (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    command_i,
  input  wire logic [scc_pkg::SECTOR_W-1:0]  sector_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [scc_pkg::SLOT_W-1:0]    slot_o,
  output logic                               hit_o,
  output logic                               writeback_o,
  output logic      [scc_pkg::SECTOR_W-1:0]  writeback_sector_o,
  output logic                               fill_o,
  output logic                               last_o
);

  import scc_pkg::*;

  scc_cmd_t    cmd;
  scc_status_t status;

  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  scc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .command_i          (command_i),
    .sector_i           (sector_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .slot_o             (slot_o),
    .hit_o              (hit_o),
    .writeback_o        (writeback_o),
    .writeback_sector_o (writeback_sector_o),
    .fill_o             (fill_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire
